[hdl/bcw_pkg.sv]
// Package for the barycentric weights unit: payload structs and fixed widths.
// Depends on nothing; used by every file in hdl.
package bcw_pkg;
  localparam int COORD_BITS = 16;
  localparam int WEIGHT_BITS = 32;

  typedef struct packed {
    logic [COORD_BITS-1:0] vertex_a_x;
    logic [COORD_BITS-1:0] vertex_a_y;
    logic [COORD_BITS-1:0] vertex_b_x;
    logic [COORD_BITS-1:0] vertex_b_y;
    logic [COORD_BITS-1:0] vertex_c_x;
    logic [COORD_BITS-1:0] vertex_c_y;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic signed [WEIGHT_BITS-1:0] weight_a;
    logic signed [WEIGHT_BITS-1:0] weight_b;
    logic signed [WEIGHT_BITS-1:0] weight_c;
    logic                          degenerate;
  } out_item_t;
endpackage

[hdl/bcw_front.sv]
// Front part: edge differences, cross products and degenerate test, three stages.
// Depends on bcw_pkg.
module bcw_front #(
  parameter int CB = 16,
  parameter int PB = 2 * CB + 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_v,
  input  bcw_pkg::in_item_t    in_d,
  output logic                 out_v,
  output logic signed [PB-1:0] s_o,
  output logic signed [PB-1:0] t_o,
  output logic signed [PB-1:0] uz_o,
  output logic                 deg_o
);
  import bcw_pkg::*;
  localparam int DB = CB + 1;
  localparam int MB = 2 * DB;

  logic signed [DB-1:0] e1x, e1y, e2x, e2y, dx, dy;
  logic signed [MB-1:0] m0, m1, m2, m3, m4, m5;
  logic [1:0] v;

  function automatic logic signed [DB-1:0] sx(input logic [CB-1:0] x);
    sx = DB'($signed(x));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_v <= 1'b0;
    end else if (en) begin
      v <= {v[0], in_v};
      out_v <= v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1x <= sx(in_d.vertex_c_x) - sx(in_d.vertex_a_x);
      e1y <= sx(in_d.vertex_c_y) - sx(in_d.vertex_a_y);
      e2x <= sx(in_d.vertex_b_x) - sx(in_d.vertex_a_x);
      e2y <= sx(in_d.vertex_b_y) - sx(in_d.vertex_a_y);
      dx  <= sx(in_d.vertex_a_x) - sx(in_d.point_x);
      dy  <= sx(in_d.vertex_a_y) - sx(in_d.point_y);
      m0 <= e2x * dy;
      m1 <= dx * e2y;
      m2 <= dx * e1y;
      m3 <= e1x * dy;
      m4 <= e1x * e2y;
      m5 <= e2x * e1y;
      s_o  <= PB'(m0) - PB'(m1);
      t_o  <= PB'(m2) - PB'(m3);
      uz_o <= PB'(m4) - PB'(m5);
      deg_o <= (m4 == m5);
    end
  end
endmodule

[hdl/bcw_fifo.sv]
// Short queue between front and back; holds cross products of each item.
// Depends on bcw_pkg.
module bcw_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         nonempty,
  output logic [$clog2(DEPTH):0] count
);
  import bcw_pkg::*;
  localparam int AB = $clog2(DEPTH);
  logic [W-1:0] mem [DEPTH];
  logic [AB-1:0] wp, rp;

  assign nonempty = count != '0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      count <= count + (AB+1)'(wr) - (AB+1)'(rd);
    end
  end
endmodule

[hdl/bcw_back.sv]
// Back part: three pipelined restoring dividers, saturation and w0 forming.
// Depends on bcw_pkg.
module bcw_back #(
  parameter int PB = 36,
  parameter int FB = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_v,
  input  logic signed [PB-1:0] s_i,
  input  logic signed [PB-1:0] t_i,
  input  logic signed [PB-1:0] uz_i,
  input  logic                 deg_i,
  output logic                 out_v,
  output bcw_pkg::out_item_t   out_d
);
  import bcw_pkg::*;
  localparam int NB = PB + 1;
  localparam int QB = NB + FB;
  localparam int ST = QB;
  localparam int QLB = 40 - FB;
  localparam int AB = 43;

  logic              v   [ST+1];
  logic              dg  [ST+1];
  logic              ng  [ST+1][3];
  logic [NB-1:0]     d   [ST+1];
  logic [NB-1:0]     r   [ST+1][3];
  logic [QB-1:0]     q   [ST+1][3];
  logic [QB-1:0]     n   [ST+1][3];

  logic signed [NB-1:0] num [3];
  always_comb begin
    num[0] = NB'(s_i) + NB'(t_i);
    num[1] = NB'(t_i);
    num[2] = NB'(s_i);
  end

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else if (en) v[0] <= in_v;
    if (en) begin
      dg[0] <= deg_i;
      d[0]  <= uz_i[PB-1] ? NB'(-uz_i) : NB'(uz_i);
      for (int k = 0; k < 3; k++) begin
        ng[0][k] <= num[k][NB-1] ^ uz_i[PB-1];
        n[0][k]  <= {(num[k][NB-1] ? -num[k] : num[k]), FB'(0)};
        r[0][k]  <= '0;
        q[0][k]  <= '0;
      end
    end
  end

  for (genvar i = 0; i < ST; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else if (en) v[i+1] <= v[i];
      if (en) begin
        dg[i+1] <= dg[i];
        d[i+1]  <= d[i];
        for (int k = 0; k < 3; k++) begin
          logic [NB:0] tr;
          tr = {r[i][k], n[i][k][QB-1]};
          ng[i+1][k] <= ng[i][k];
          n[i+1][k]  <= {n[i][k][QB-2:0], 1'b0};
          if (tr >= {1'b0, d[i]}) begin
            r[i+1][k] <= NB'(tr - {1'b0, d[i]});
            q[i+1][k] <= {q[i][k][QB-2:0], 1'b1};
          end else begin
            r[i+1][k] <= NB'(tr);
            q[i+1][k] <= {q[i][k][QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  function automatic logic signed [AB-1:0] clampq(input logic [QB-1:0] x, input logic neg);
    logic [AB-1:0] m;
    m = ((x >> FB) >= QB'(64'(1) << QLB)) ? (AB'(1) << 40) : AB'(x);
    clampq = neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [WEIGHT_BITS-1:0] sat(input logic signed [AB-1:0] x);
    if (x > AB'(32'sh7fffffff)) sat = 32'sh7fffffff;
    else if (x < -AB'(33'sh080000000)) sat = 32'sh80000000;
    else sat = WEIGHT_BITS'(x);
  endfunction

  logic signed [AB-1:0] one, w0;
  assign one = AB'(1) << FB;
  assign w0 = one - clampq(q[ST][0], ng[ST][0]);

  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (en) out_v <= v[ST];
    if (en) begin
      if (dg[ST]) begin
        out_d.weight_a <= sat(-one);
        out_d.weight_b <= sat(-one);
        out_d.weight_c <= sat(-one);
      end else begin
        out_d.weight_a <= sat(w0);
        out_d.weight_b <= sat(clampq(q[ST][1], ng[ST][1]));
        out_d.weight_c <= sat(clampq(q[ST][2], ng[ST][2]));
      end
      out_d.degenerate <= dg[ST];
    end
  end
endmodule

[hdl/barycentric_weights_unit.sv]
// Top level of the barycentric weights unit: front, queue and back.
// Depends on bcw_pkg, bcw_front, bcw_fifo, bcw_back.
//   channel | signals                        | payload
//   input   | in_valid, in_ready, in_data    | bcw_pkg::in_item_t
//   output  | out_valid, out_ready, out_data | bcw_pkg::out_item_t
// One item per cycle sustained while the output is taken. An item passes from the
// first front stage through 2 more front stages, 1 queue entry, 1 divider load
// stage, 2*COORD_BITS+5+FRAC_BITS divider stages and the output register.
// Reset clears all valid flags and queue pointers.
// The input is refused only when the queue could overflow; the back stalls when
// the output register holds an untaken item.
module barycentric_weights_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bcw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bcw_pkg::out_item_t out_data
);
  import bcw_pkg::*;
  localparam int PB = 2 * COORD_BITS + 4;
  localparam int DEPTH = 8;
  localparam int CW = $clog2(DEPTH) + 1;

  logic fv, fd, qne, bv, back_en;
  logic signed [PB-1:0] fs, ft, fz;
  logic [3*PB:0] qd;
  logic [CW-1:0] cnt;

  assign in_ready = cnt <= CW'(DEPTH - 4);

  bcw_front #(.CB(COORD_BITS), .PB(PB)) u_front (
    .clk, .rst, .en(1'b1), .in_v(in_valid && in_ready), .in_d(in_data),
    .out_v(fv), .s_o(fs), .t_o(ft), .uz_o(fz), .deg_o(fd)
  );

  bcw_fifo #(.W(3*PB+1), .DEPTH(DEPTH)) u_fifo (
    .clk, .rst, .wr(fv), .wdata({fs, ft, fz, fd}),
    .rd(back_en && qne), .rdata(qd), .nonempty(qne), .count(cnt)
  );

  assign back_en = !out_valid || out_ready;

  bcw_back #(.PB(PB), .FB(FRAC_BITS)) u_back (
    .clk, .rst, .en(back_en), .in_v(qne),
    .s_i(qd[3*PB:2*PB+1]), .t_i(qd[2*PB:PB+1]), .uz_i(qd[PB:1]), .deg_i(qd[0]),
    .out_v(bv), .out_d(out_data)
  );

  assign out_valid = bv;

  a_ovf: assert property (@(posedge clk) disable iff (rst) fv |-> cnt < CW'(DEPTH))
    else $error("queue overflow");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");
  a_deg: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |-> out_data.weight_b == out_data.weight_c)
    else $error("degenerate weights differ");
endmodule

[sim/tb_top.sv]
// Testbench for barycentric_weights_unit: random and directed triangles with a
// scoreboard that predicts the Q15.16 weights. Depends on bcw_pkg and the RTL.
module tb_top;
  import bcw_pkg::*;

  localparam int ONE_Q = 1 << 16;
  localparam longint QLIM = 64'sd1 << 40;
  localparam int WATCH_LIMIT = 20000;
  localparam int LONG_HOLD = 400;

  class weight_board;
    out_item_t pending[$];
    int errors;

    function longint fix_div(longint num, longint den);
      bit neg;
      longint unsigned n, d, q, r;
      neg = (num < 0) != (den < 0);
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      q = n / d;
      r = n % d;
      if (q >= (64'd1 << 24)) q = QLIM;
      else begin
        for (int i = 0; i < 16; i++) begin
          r = r << 1;
          q = q << 1;
          if (r >= d) begin
            r = r - d;
            q = q | 1;
          end
        end
      end
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
    endfunction

    function void note_input(in_item_t it);
      longint ax, ay, bx, by, cx, cy, px, py, e1x, e1y, e2x, e2y, dx, dy, s, t, uz;
      out_item_t w;
      ax = longint'($signed(it.vertex_a_x)); ay = longint'($signed(it.vertex_a_y));
      bx = longint'($signed(it.vertex_b_x)); by = longint'($signed(it.vertex_b_y));
      cx = longint'($signed(it.vertex_c_x)); cy = longint'($signed(it.vertex_c_y));
      px = longint'($signed(it.point_x)); py = longint'($signed(it.point_y));
      e1x = cx - ax; e1y = cy - ay; e2x = bx - ax; e2y = by - ay;
      dx = ax - px; dy = ay - py;
      s = e2x * dy - dx * e2y;
      t = dx * e1y - e1x * dy;
      uz = e1x * e2y - e2x * e1y;
      if (uz == 0) begin
        w.weight_a = -ONE_Q; w.weight_b = -ONE_Q; w.weight_c = -ONE_Q;
        w.degenerate = 1'b1;
      end else begin
        w.weight_a = clamp32(longint'(ONE_Q) - fix_div(s + t, uz));
        w.weight_b = clamp32(fix_div(t, uz));
        w.weight_c = clamp32(fix_div(s, uz));
        w.degenerate = 1'b0;
      end
      pending.push_back(w);
    endfunction

    task check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      e = pending.pop_front();
      if (got.weight_a !== e.weight_a)
        report($sformatf("weight_a %0d exp %0d", got.weight_a, e.weight_a));
      if (got.weight_b !== e.weight_b)
        report($sformatf("weight_b %0d exp %0d", got.weight_b, e.weight_b));
      if (got.weight_c !== e.weight_c)
        report($sformatf("weight_c %0d exp %0d", got.weight_c, e.weight_c));
      if (got.degenerate !== e.degenerate)
        report($sformatf("degenerate %0b exp %0b", got.degenerate, e.degenerate));
    endtask

    task report(string msg);
      errors++;
      if (errors <= 50) $display("mismatch: %s", msg);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  weight_board board = new();
  bit stim_done = 1'b0;
  bit hold_rx = 1'b0;
  int idle_cycles = 0;

  barycentric_weights_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  function logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom());
      1: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return $urandom_range(0, 3) == 0 ? 16'h8000 :
                      ($urandom_range(0, 1) ? 16'h7fff : 16'h0000);
    endcase
  endfunction

  function in_item_t rand_tri();
    in_item_t it;
    int mode;
    mode = $urandom_range(0, 9) < 5 ? 0 : ($urandom_range(0, 4) == 0 ? 2 : 1);
    it = {rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
          rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode)};
    if ($urandom_range(0, 9) == 0) begin
      it.vertex_c_x = it.vertex_b_x;
      it.vertex_c_y = it.vertex_b_y;
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(it);
  endtask

  task automatic pause_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    in_item_t it;
    int g;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    it = '0; send_item(it);
    it = {16'h0000, 16'h0000, 16'h0010, 16'h0000, 16'h0000, 16'h0010, 16'h0004, 16'h0004};
    send_item(it);
    it.point_x = 16'h0000; it.point_y = 16'h0000; send_item(it);
    it.point_x = 16'h0010; send_item(it);
    it.point_x = 16'h7fff; it.point_y = 16'h8000; send_item(it);
    it = {16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff};
    send_item(it);
    it = {16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 16'h1234, 16'hedcb};
    send_item(it);
    it = {16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h8000, 16'h7fff};
    send_item(it);
    it = {16'h0000, 16'h0000, 16'h0002, 16'h0001, 16'h0001, 16'h0001, 16'h7fff, 16'h8000};
    send_item(it);
    it = {16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff};
    send_item(it);
    it = {16'h0000, 16'h0000, 16'h0003, 16'h0000, 16'h0000, 16'hfffd, 16'h0001, 16'hffff};
    send_item(it);
    drain_wait();
    hold_rx = 1'b1;
    for (int i = 0; i < 1200; i++) begin
      send_item(rand_tri());
      if (i == 600) drain_wait();
      g = gap_len();
      if (g > 0) pause_sender(g);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int n;
    bit held;
    held = 1'b0;
    @(negedge rst);
    while (1) begin
      if (hold_rx && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        n = gap_len();
        out_ready <= (n == 0);
        @(posedge clk);
        if (n > 0) begin
          repeat (n - 1) @(posedge clk);
          out_ready <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_data);
    if (!rst && ((in_valid && in_ready) || (out_valid && out_ready))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= WATCH_LIMIT);
    $display("status: fail");
    $finish;
  end
endmodule

[barycentric_weights_unit.f]
hdl/bcw_pkg.sv
hdl/bcw_front.sv
hdl/bcw_fifo.sv
hdl/bcw_back.sv
hdl/barycentric_weights_unit.sv
sim/tb_top.sv
